FILE: sv/sos_duplicate_filter_alert_assert.svh
// Assertion macros used by the checker file of the SOS duplicate filter.
// Depends on nothing; included by bare file name.
`ifndef SOS_DUPLICATE_FILTER_ALERT_ASSERT_SVH
`define SOS_DUPLICATE_FILTER_ALERT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SDFA_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("sdfa assertion failed");

// next-cycle implication, disabled in reset
`define SDFA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("sdfa assertion failed");

`endif

FILE: sv/sdfa_pkg.sv
// Types, constants and helpers of the SOS duplicate filter with alert timers.
// No dependencies; the files that use it refer to it by scoped names.
package sdfa_pkg;

    localparam int CACHE_ENTRIES = 10;
    localparam int SEQ_BITS      = 32;
    localparam int NODE_BITS     = 16;

    // key bits actually compared: the field widths cap the configured widths
    localparam int NODE_W  = (NODE_BITS < 16) ? NODE_BITS : 16;
    localparam int SEQ_W   = (SEQ_BITS < 32) ? SEQ_BITS : 32;
    localparam int KEY_W   = NODE_W + SEQ_W;
    localparam int IDX_W   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int TIMER_W = 16;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_TTL_LIMIT    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_BUZZER_TICKS = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_ALERT_TICKS  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_TICKS   = CFG_INDEX_W'(3);

    localparam logic [3:0]         TTL_LIMIT_RST    = 4'd5;
    localparam logic [TIMER_W-1:0] BUZZER_TICKS_RST = TIMER_W'(2500);
    localparam logic [TIMER_W-1:0] ALERT_TICKS_RST  = TIMER_W'(8000);
    localparam logic [TIMER_W-1:0] PAGE_TICKS_RST   = TIMER_W'(2000);
    localparam logic [1:0]         PAGE_LAST        = 2'd3;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        VERDICT_REJECT = 2'd0,
        VERDICT_NEW    = 2'd1,
        VERDICT_DUP    = 2'd2,
        VERDICT_TICK   = 2'd3
    } verdict_t;

    typedef struct packed {
        logic        operation;
        logic        format_ok;
        logic [15:0] node_id;
        logic [31:0] seq_number;
        logic [7:0]  hop_ttl;
    } item_t;

    typedef struct packed {
        verdict_t   verdict;
        logic       ack_request;
        logic       buzzer_level;
        logic       alert_level;
        logic [1:0] page_shown;
    } result_t;

    typedef struct packed {
        logic [3:0]         ttl_limit;
        logic [TIMER_W-1:0] buzzer_ticks;
        logic [TIMER_W-1:0] alert_ticks;
        logic [TIMER_W-1:0] page_ticks;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic insert;
    } lk_cmd_t;

    typedef struct packed {
        logic done;
        logic hit;
    } lk_status_t;

    typedef struct packed {
        logic tick;
        logic start;
    } tm_ctl_t;

    typedef struct packed {
        logic       buzzer;
        logic       alert;
        logic [1:0] page;
    } levels_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_FINISH
    } top_state_t;

    typedef enum logic {
        LK_IDLE,
        LK_SCAN
    } lk_state_t;

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
        return (v == {TIMER_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

FILE: sv/sdfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/sdfa_lookup.sv
// Cache of (node, sequence) keys: one RAM, valid flops, round-robin insert.
// Walks the entries one per cycle through the RAM read port. Uses sdfa_pkg, sdfa_ram.
module sdfa_lookup (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdfa_pkg::key_t       key,
    input  sdfa_pkg::lk_cmd_t    cmd,
    output sdfa_pkg::lk_status_t status
);

    sdfa_pkg::lk_state_t                 state_reg, state_next;
    logic [sdfa_pkg::IDX_W-1:0]          idx_reg, idx_next;
    logic [sdfa_pkg::IDX_W-1:0]          ptr_reg;
    logic [sdfa_pkg::CACHE_ENTRIES-1:0]  valid_reg;
    logic                                re;
    logic [sdfa_pkg::IDX_W-1:0]          raddr;
    sdfa_pkg::key_t                      rdata;
    logic                                last;
    logic                                match;

    sdfa_ram #(
        .WIDTH(sdfa_pkg::KEY_W),
        .DEPTH(sdfa_pkg::CACHE_ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (cmd.insert),
        .waddr(ptr_reg),
        .wdata(key),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign last  = (idx_reg == sdfa_pkg::IDX_W'(sdfa_pkg::CACHE_ENTRIES - 1));
    assign match = valid_reg[idx_reg] && (rdata == key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdfa_pkg::LK_IDLE;
            idx_reg   <= '0;
            ptr_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cmd.insert)
            begin
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg <= (ptr_reg == sdfa_pkg::IDX_W'(sdfa_pkg::CACHE_ENTRIES - 1))
                           ? '0 : ptr_reg + 1'b1;
            end
        end
    end

    // idx_reg names the entry whose data sits on rdata this cycle
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        re          = 1'b0;
        raddr       = '0;
        status.done = 1'b0;
        status.hit  = 1'b0;
        unique case (state_reg)
            sdfa_pkg::LK_IDLE:
            begin
                if (cmd.start)
                begin
                    re         = 1'b1;
                    idx_next   = '0;
                    state_next = sdfa_pkg::LK_SCAN;
                end
            end
            sdfa_pkg::LK_SCAN:
            begin
                if (match || last)
                begin
                    status.done = 1'b1;
                    status.hit  = match;
                    state_next  = sdfa_pkg::LK_IDLE;
                end
                else
                begin
                    re       = 1'b1;
                    raddr    = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = sdfa_pkg::LK_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/sdfa_timers.sv
// Buzzer, alert and display page timers, advanced by ticks, restarted by a new SOS.
// Presents the levels that hold after the current commit. Uses sdfa_pkg.
module sdfa_timers (
    input  logic              clk,
    input  logic              rst_n,
    input  sdfa_pkg::cfg_t    cfg,
    input  sdfa_pkg::tm_ctl_t ctl,
    output sdfa_pkg::levels_t levels
);

    logic                         buzzer_active_reg, buzzer_active_next;
    logic                         alert_active_reg, alert_active_next;
    logic [sdfa_pkg::TIMER_W-1:0] buzzer_elapsed_reg, buzzer_elapsed_next;
    logic [sdfa_pkg::TIMER_W-1:0] alert_elapsed_reg, alert_elapsed_next;
    logic [sdfa_pkg::TIMER_W-1:0] page_elapsed_reg, page_elapsed_next;
    logic [1:0]                   page_index_reg, page_index_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buzzer_active_reg  <= 1'b0;
            alert_active_reg   <= 1'b0;
            buzzer_elapsed_reg <= '0;
            alert_elapsed_reg  <= '0;
            page_elapsed_reg   <= '0;
            page_index_reg     <= '0;
        end
        else
        begin
            buzzer_active_reg  <= buzzer_active_next;
            alert_active_reg   <= alert_active_next;
            buzzer_elapsed_reg <= buzzer_elapsed_next;
            alert_elapsed_reg  <= alert_elapsed_next;
            page_elapsed_reg   <= page_elapsed_next;
            page_index_reg     <= page_index_next;
        end
    end

    always_comb
    begin
        buzzer_active_next  = buzzer_active_reg;
        alert_active_next   = alert_active_reg;
        buzzer_elapsed_next = buzzer_elapsed_reg;
        alert_elapsed_next  = alert_elapsed_reg;
        page_elapsed_next   = page_elapsed_reg;
        page_index_next     = page_index_reg;
        if (ctl.start)
        begin
            buzzer_active_next  = 1'b1;
            alert_active_next   = 1'b1;
            buzzer_elapsed_next = '0;
            alert_elapsed_next  = '0;
            page_elapsed_next   = '0;
            page_index_next     = '0;
        end
        else if (ctl.tick)
        begin
            if (buzzer_active_reg)
            begin
                buzzer_elapsed_next = sdfa_pkg::sat_inc(buzzer_elapsed_reg);
                if (buzzer_elapsed_next >= cfg.buzzer_ticks)
                begin
                    buzzer_active_next = 1'b0;
                end
            end
            if (alert_active_reg)
            begin
                page_elapsed_next = sdfa_pkg::sat_inc(page_elapsed_reg);
                if (page_elapsed_next >= cfg.page_ticks)
                begin
                    page_elapsed_next = '0;
                    page_index_next   = (page_index_reg == sdfa_pkg::PAGE_LAST)
                                        ? 2'd0 : page_index_reg + 1'b1;
                end
                alert_elapsed_next = sdfa_pkg::sat_inc(alert_elapsed_reg);
                if (alert_elapsed_next >= cfg.alert_ticks)
                begin
                    alert_active_next = 1'b0;
                end
            end
        end
    end

    assign levels.buzzer = buzzer_active_next;
    assign levels.alert  = alert_active_next;
    assign levels.page   = page_index_next;

endmodule

FILE: sv/sos_duplicate_filter_alert.sv
// Top level of the SOS duplicate filter with buzzer, alert and page timers.
// Uses sdfa_pkg, sdfa_lookup (with sdfa_ram) and sdfa_timers.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+----------------------------------
//  item    | in        | item_valid/item_stall| sdfa_pkg::item_t (packet or tick)
//  result  | out       | result_valid/_stall  | sdfa_pkg::result_t, one per item
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data (4 registers)
//
// A tick or a rejected packet passes CHECK and FINISH; its result word is registered at the commit in FINISH.
// A packet that reaches the cache walks it with one comparator on the RAM's single
// read port, one entry a cycle, stopping at the first hit.
// One item is in work at a time; the next is taken once the result is registered.
// Reset clears the valid flops, pointer and timers at once; there is no sweep.
// A stalled result holds the finished item in FINISH until the output slot frees.
module sos_duplicate_filter_alert (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  sdfa_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output sdfa_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sdfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sdfa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    sdfa_pkg::top_state_t state_reg, state_next;
    sdfa_pkg::item_t      item_reg;
    sdfa_pkg::verdict_t   verdict_reg, verdict_next;
    sdfa_pkg::cfg_t       cfg_reg;
    sdfa_pkg::result_t    result_reg;
    logic                 result_valid_reg;
    logic                 commit;
    sdfa_pkg::key_t       key;
    sdfa_pkg::lk_cmd_t    lk_cmd;
    sdfa_pkg::lk_status_t lk_status;
    sdfa_pkg::tm_ctl_t    tm_ctl;
    sdfa_pkg::levels_t    levels;

    // compared key: the low bits of node and sequence the cache keeps
    assign key = {item_reg.node_id[sdfa_pkg::NODE_W-1:0],
                  item_reg.seq_number[sdfa_pkg::SEQ_W-1:0]};

    sdfa_lookup u_lookup (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (key),
        .cmd   (lk_cmd),
        .status(lk_status)
    );

    sdfa_timers u_timers (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .ctl   (tm_ctl),
        .levels(levels)
    );

    assign item_stall   = (state_reg != sdfa_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    // configuration registers; index beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ttl_limit    <= sdfa_pkg::TTL_LIMIT_RST;
            cfg_reg.buzzer_ticks <= sdfa_pkg::BUZZER_TICKS_RST;
            cfg_reg.alert_ticks  <= sdfa_pkg::ALERT_TICKS_RST;
            cfg_reg.page_ticks   <= sdfa_pkg::PAGE_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sdfa_pkg::CFG_TTL_LIMIT:    cfg_reg.ttl_limit    <= cfg_data[3:0];
                sdfa_pkg::CFG_BUZZER_TICKS: cfg_reg.buzzer_ticks <= cfg_data;
                sdfa_pkg::CFG_ALERT_TICKS:  cfg_reg.alert_ticks  <= cfg_data;
                sdfa_pkg::CFG_PAGE_TICKS:   cfg_reg.page_ticks   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sdfa_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
        if (commit)
        begin
            result_reg.verdict      <= verdict_reg;
            result_reg.ack_request  <= (verdict_reg == sdfa_pkg::VERDICT_NEW) ||
                                       (verdict_reg == sdfa_pkg::VERDICT_DUP);
            result_reg.buzzer_level <= levels.buzzer;
            result_reg.alert_level  <= levels.alert;
            result_reg.page_shown   <= levels.page;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        verdict_next  = verdict_reg;
        commit        = 1'b0;
        lk_cmd.start  = 1'b0;
        lk_cmd.insert = 1'b0;
        tm_ctl.tick   = 1'b0;
        tm_ctl.start  = 1'b0;
        unique case (state_reg)
            sdfa_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = sdfa_pkg::ST_CHECK;
                end
            end
            sdfa_pkg::ST_CHECK:
            begin
                if (item_reg.operation == sdfa_pkg::OP_TICK)
                begin
                    verdict_next = sdfa_pkg::VERDICT_TICK;
                    state_next   = sdfa_pkg::ST_FINISH;
                end
                else if (!item_reg.format_ok ||
                         (item_reg.hop_ttl > {4'b0, cfg_reg.ttl_limit}))
                begin
                    verdict_next = sdfa_pkg::VERDICT_REJECT;
                    state_next   = sdfa_pkg::ST_FINISH;
                end
                else
                begin
                    lk_cmd.start = 1'b1;
                    state_next   = sdfa_pkg::ST_WALK;
                end
            end
            sdfa_pkg::ST_WALK:
            begin
                if (lk_status.done)
                begin
                    verdict_next = lk_status.hit ? sdfa_pkg::VERDICT_DUP
                                                 : sdfa_pkg::VERDICT_NEW;
                    state_next   = sdfa_pkg::ST_FINISH;
                end
            end
            sdfa_pkg::ST_FINISH:
            begin
                // state changes land together with the result word
                if (!result_valid_reg || !result_stall)
                begin
                    commit        = 1'b1;
                    tm_ctl.tick   = (verdict_reg == sdfa_pkg::VERDICT_TICK);
                    tm_ctl.start  = (verdict_reg == sdfa_pkg::VERDICT_NEW);
                    lk_cmd.insert = (verdict_reg == sdfa_pkg::VERDICT_NEW);
                    state_next    = sdfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdfa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/sdfa_checker.sv
// Port-level checks of the SOS duplicate filter, bound to the top level.
// Uses sdfa_pkg and the macros of sos_duplicate_filter_alert_assert.svh.
`include "sos_duplicate_filter_alert_assert.svh"

module sdfa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input sdfa_pkg::result_t result
);

    logic item_take;
    logic new_word;
    logic stalled_word;
    logic new_levels;

    assign item_take    = item_valid && !item_stall;
    assign new_word     = result_valid && (result.verdict == sdfa_pkg::VERDICT_NEW);
    assign stalled_word = result_valid && result_stall;
    assign new_levels   = result.buzzer_level && result.alert_level &&
                          (result.page_shown == 2'd0) && result.ack_request;

    // stalled result word holds
    `SDFA_ASSERT_NEXT(a_result_hold, clk, rst_n, stalled_word, result_valid && $stable(result))

    // one item in work at a time
    `SDFA_ASSERT_NEXT(a_busy_after_take, clk, rst_n, item_take, item_stall)

    // a result word only appears after an item went in
    `SDFA_ASSERT_NOW(a_result_has_item, clk, rst_n, $rose(result_valid), $past(item_stall))

    // a new SOS restarts buzzer, alert and page
    `SDFA_ASSERT_NOW(a_new_starts_alert, clk, rst_n, new_word, new_levels)

endmodule

bind sos_duplicate_filter_alert sdfa_checker u_checker (.*);
